/* sv/skt_pkg.sv */
// Shared constants, codes and interface types of the sorted key table.
package skt_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 16;
  localparam int REC_W    = 38;
  localparam int TOT_W    = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int GROUP    = 8;
  localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture record and per-cell compare flags
    logic ins;    // commit insert shift
    logic del;    // commit delete shift
  } skt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             hit;
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] count;
  } skt_stat_t;

endpackage

/* sv/skt_cells.sv */
// Datapath: row of record cells with local compare flags and grouped match tree.
module skt_cells (
  input  logic                  clk,
  input  logic                  rst_n,
  input  skt_pkg::skt_cmd_t     cmd,
  input  logic [skt_pkg::KEY_W-1:0] in_key,
  input  logic [skt_pkg::REC_W-1:0] in_rec,
  output skt_pkg::skt_stat_t    stat
);
  import skt_pkg::*;

  logic [REC_W-1:0]  cell_r [CAPACITY];
  logic [REC_W-1:0]  rec_r;
  logic [CAPACITY-1:0] gt_r, ge_r;
  logic [CAPACITY-1:0] gt_nxt, ge_nxt;
  logic [NGROUP*GROUP-1:0] eq_pad;
  logic [NGROUP-1:0] grp_r, grp_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // per-cell flags, validity folded in (only slots below the count compare)
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt_nxt[i] = (CNT_W'(i) < count_r) && (cell_r[i][REC_W-1 -: KEY_W] > in_key);
      ge_nxt[i] = (CNT_W'(i) < count_r) && (cell_r[i][REC_W-1 -: KEY_W] >= in_key);
    end
  end

  always_comb begin
    eq_pad = '0;
    eq_pad[CAPACITY-1:0] = ge_r & ~gt_r;
    for (int g = 0; g < NGROUP; g++) begin
      grp_nxt[g] = |eq_pad[g*GROUP +: GROUP];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rec_r <= in_rec;
      gt_r  <= gt_nxt;
      ge_r  <= ge_nxt;
    end
    grp_r <= grp_nxt;
  end

  // insert: cells above the sorted place take their lower neighbor
  // delete: cells at or above the match take their upper neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_bot
      always_ff @(posedge clk) begin
        if (cmd.ins && (gt_r[i] || (count_r == CNT_W'(i)))) begin
          cell_r[i] <= rec_r;
        end else if (cmd.del && ge_r[i]) begin
          cell_r[i] <= cell_r[i+1];
        end
      end
    end else if (i == CAPACITY - 1) begin : g_top
      always_ff @(posedge clk) begin
        if (cmd.ins && (gt_r[i] || (count_r == CNT_W'(i)))) begin
          cell_r[i] <= gt_r[i-1] ? cell_r[i-1] : rec_r;
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.ins && (gt_r[i] || (count_r == CNT_W'(i)))) begin
          cell_r[i] <= gt_r[i-1] ? cell_r[i-1] : rec_r;
        end else if (cmd.del && ge_r[i]) begin
          cell_r[i] <= cell_r[i+1];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign stat.hit   = |grp_r;
  assign stat.full  = (count_r == CNT_W'(CAPACITY));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");
  a_no_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |-> !stat.full)
    else $error("insert committed into full table");
  a_no_del_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.del |-> !stat.empty)
    else $error("delete committed on empty table");
`endif

endmodule

/* sv/skt_ctrl.sv */
// Controller: transaction sequencing, status decision and result register.
module skt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_status,
  output logic [skt_pkg::TOT_W-1:0] out_entry_total,
  output skt_pkg::skt_cmd_t     cmd,
  input  skt_pkg::skt_stat_t    stat
);
  import skt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RED, S_DEC} state_t;

  state_t           state_r;
  logic             action_r;
  logic             out_valid_r;
  status_t          out_status_r;
  logic [TOT_W-1:0] out_total_r;

  logic       accept, out_free, fire;
  status_t    status_nxt;
  logic [CNT_W-1:0] count_after;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = (state_r == S_DEC) && out_free;

  always_comb begin
    status_nxt = ST_OK;
    cmd.load   = accept;
    cmd.ins    = 1'b0;
    cmd.del    = 1'b0;
    if (action_r == ACT_INSERT) begin
      if (stat.full) begin
        status_nxt = ST_FULL;
      end else if (stat.hit) begin
        status_nxt = ST_DUP;
      end else begin
        cmd.ins = fire;
      end
    end else begin
      if (stat.empty) begin
        status_nxt = ST_EMPTY;
      end else if (!stat.hit) begin
        status_nxt = ST_NOTFOUND;
      end else begin
        cmd.del = fire;
      end
    end
    count_after = stat.count;
    if (cmd.ins) begin
      count_after = stat.count + CNT_W'(1);
    end else if (cmd.del) begin
      count_after = stat.count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // new result replaces the one taken at this edge
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            action_r <= in_action;
            state_r  <= S_RED;
          end
        end
        S_RED: begin
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (out_free) begin
            out_status_r <= status_nxt;
            out_total_r  <= TOT_W'(count_after);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_total = out_total_r;

`ifndef SYNTH
  a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ins && cmd.del))
    else $error("insert and delete committed together");
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_RED) ##1 (state_r == S_DEC))
    else $error("transaction did not advance to decision");
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DEC))
    else $error("result raised outside decision step");
`endif

endmodule

/* sv/sorted_key_table.sv */
// Top level of the sorted key table: controller plus cell-row datapath.
//
// Holds up to 64 timetable records in ascending key order. Each input
// transaction is an insert (action 0) or a delete by key (action 1) and
// yields exactly one result transaction: a status code (0 ok, 1 full,
// 2 duplicate key, 3 key not found, 4 empty) and the record count after the
// operation. A full table is reported before a duplicate on insert, an empty
// table before a missing key on delete. A transaction is accepted only while
// no other is in flight; its result is registered in the decision step once
// the output register is free, and the next transaction can be taken only
// after that. The three steps are the per-cell key compare (every cell at
// once), the grouped match tree (eight-cell groups, registered) and the
// decision with the parallel shift of the cell row. A result waiting on
// out_stall does not block acceptance of the next transaction. No clearing
// pass after reset: slots above the count are never looked at.
module sorted_key_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [15:0] in_key,
  input  logic [4:0]  in_dep_hour,
  input  logic [5:0]  in_dep_minute,
  input  logic [4:0]  in_arr_hour,
  input  logic [5:0]  in_arr_minute,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [6:0]  out_entry_total
);
  import skt_pkg::*;

  skt_cmd_t         cmd;
  skt_stat_t        stat;
  logic [REC_W-1:0] rec;

  // record layout: key, departure hour/minute, arrival hour/minute
  assign rec = {in_key, in_dep_hour, in_dep_minute, in_arr_hour, in_arr_minute};

  skt_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_total (out_entry_total),
    .cmd             (cmd),
    .stat            (stat)
  );

  skt_cells u_cells (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .in_key (in_key),
    .in_rec (rec),
    .stat   (stat)
  );

endmodule

/* dv/tb_sorted_key_table.sv */
// Self-checking testbench for sorted_key_table: directed op table plus randomized traffic.
`timescale 1ns / 100ps

module tb_sorted_key_table;
  import skt_pkg::*;

  localparam int CLK_HALF    = 4;       // 8 ns period
  localparam int RESET_CYC   = 7;
  localparam int PHASE_ITEMS = 375;     // four idle phases -> ~1500 random transactions
  localparam int DRAIN_CYC   = 12;      // settle time after the last result
  localparam int CYCLE_LIMIT = 300000;  // far above the slowest legal run
  localparam int KEY_STRIDE  = 683;     // spreads the small key pool over the 16-bit range

  // One expected result transaction.
  typedef struct packed {
    status_t          status;
    logic [TOT_W-1:0] total;
  } outcome_t;

  // One row of the directed table. Rows with "pinned" set carry a hand-typed
  // result; the others are checked against the shadow table only.
  typedef struct {
    logic        act;
    logic [15:0] key;
    logic [4:0]  dh;
    logic [5:0]  dm;
    logic [4:0]  ah;
    logic [5:0]  am;
    bit          pinned;
    status_t     st;
    int          tot;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // DUT ports. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = ACT_INSERT;
  logic [15:0] in_key = '0;
  logic [4:0]  in_dep_hour = '0;
  logic [5:0]  in_dep_minute = '0;
  logic [4:0]  in_arr_hour = '0;
  logic [5:0]  in_arr_minute = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [6:0]  out_entry_total;

  sorted_key_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_dep_hour     (in_dep_hour),
    .in_dep_minute   (in_dep_minute),
    .in_arr_hour     (in_arr_hour),
    .in_arr_minute   (in_arr_minute),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_total (out_entry_total)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the sorted record table. Slots 0 .. shadow_count-1 are live,
  // kept in ascending key order; {key, dep_h, dep_m, arr_h, arr_m}.
  // ---------------------------------------------------------------------------
  logic [REC_W-1:0] shadow_recs [CAPACITY];
  int               shadow_count = 0;
  int               peak_count   = 0;

  outcome_t expected_q [$];

  int errors       = 0;
  int cycles       = 0;
  int n_insert     = 0;
  int n_delete     = 0;
  int status_seen [5];

  // Knobs moved by the stimulus process; percent per cycle.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Hand-typed expectation for the transaction currently on the input port.
  bit       pin_on = 1'b0;
  outcome_t pin_res;

  // Apply one insert/delete to the shadow table and return its outcome.
  // Full is checked before duplicate, empty before missing key.
  function automatic outcome_t table_update(input logic act, input logic [15:0] key,
                                            input logic [4:0] dh, input logic [5:0] dm,
                                            input logic [4:0] ah, input logic [5:0] am);
    outcome_t res;
    bit       found;
    int       pos;
    int       i;
    res.status = ST_OK;
    found = 1'b0;
    pos = 0;
    for (i = 0; i < shadow_count; i++) begin
      if (!found && shadow_recs[i][REC_W-1 -: KEY_W] == key) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (act == ACT_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else if (found) begin
        res.status = ST_DUP;
      end else begin
        // open a hole at the sorted position, larger keys move up
        i = shadow_count;
        while (i > 0 && shadow_recs[i-1][REC_W-1 -: KEY_W] > key) begin
          shadow_recs[i] = shadow_recs[i-1];
          i--;
        end
        shadow_recs[i] = {key, dh, dm, ah, am};
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = ST_EMPTY;
      end else if (!found) begin
        res.status = ST_NOTFOUND;
      end else begin
        for (i = pos; i + 1 < shadow_count; i++) shadow_recs[i] = shadow_recs[i+1];
        shadow_count--;
      end
    end
    res.total = shadow_count[TOT_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Input-side monitor: every accepted transaction updates the shadow table
  // and queues its expected result. Sampled at the rising edge, so the DUT's
  // own updates at this edge are not yet visible.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t res;
    if (rst_n && in_valid && !in_stall) begin
      res = table_update(in_action, in_key, in_dep_hour, in_dep_minute,
                         in_arr_hour, in_arr_minute);
      if (in_action == ACT_INSERT) n_insert++;
      else n_delete++;
      if (shadow_count > peak_count) peak_count = shadow_count;
      expected_q.push_back(pin_on ? pin_res : res);
    end
  end

  // ---------------------------------------------------------------------------
  // Output-side checker: compare each accepted result with the oldest one due.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction: status %0d total %0d",
                 $realtime, out_status, out_entry_total);
      end else begin
        want = expected_q.pop_front();
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $realtime, want.status, out_status);
        end
        if (out_entry_total !== want.total) begin
          errors++;
          $display("%0t: entry_total mismatch: expected %0d, actual %0d",
                   $realtime, want.total, out_entry_total);
        end
        if (want.status <= ST_EMPTY) status_seen[want.status]++;
      end
    end
  end

  // Receiver back-pressure, changed on the falling edge only.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sorted_key_table: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Called at a falling edge, returns at the falling edge after the
  // transaction was taken. in_valid is written once per falling edge: an idle
  // cycle lowers it, otherwise it stays high straight into the next item.
  // ---------------------------------------------------------------------------
  task automatic send_op(input logic act, input logic [15:0] key,
                         input logic [4:0] dh, input logic [5:0] dm,
                         input logic [4:0] ah, input logic [5:0] am,
                         input bit pinned, input outcome_t pres);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_key        <= key;
    in_dep_hour   <= dh;
    in_dep_minute <= dm;
    in_arr_hour   <= ah;
    in_arr_minute <= am;
    pin_on  = pinned;
    pin_res = pres;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic dir_row_t mk(input logic act, input logic [15:0] key,
                                  input logic [4:0] dh, input logic [5:0] dm,
                                  input logic [4:0] ah, input logic [5:0] am,
                                  input bit pinned, input status_t st, input int tot);
    dir_row_t r;
    r.act = act; r.key = key; r.dh = dh; r.dm = dm; r.ah = ah; r.am = am;
    r.pinned = pinned; r.st = st; r.tot = tot;
    return r;
  endfunction

  // Random transaction. Keys mostly come from a small pool so that duplicates
  // and hits are common; deletes usually aim at a key that is held. A few keys
  // are fully random or at the extremes. Times are mostly legal clock values,
  // now and then any value the field width allows.
  task automatic random_op(input int insert_pct);
    logic        act;
    logic [15:0] key;
    logic [4:0]  dh;
    logic [4:0]  ah;
    logic [5:0]  dm;
    logic [5:0]  am;
    int          sel;
    outcome_t    none;
    none = '0;
    act = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_DELETE;
    sel = $urandom_range(9);
    if (act == ACT_DELETE && shadow_count > 0 && sel < 7)
      key = shadow_recs[$urandom_range(shadow_count - 1)][REC_W-1 -: KEY_W];
    else if (sel == 9)
      key = 16'($urandom());
    else if (sel == 8)
      key = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    else
      key = 16'($urandom_range(95) * KEY_STRIDE);
    if ($urandom_range(9) == 0) begin
      dh = 5'($urandom()); dm = 6'($urandom());
      ah = 5'($urandom()); am = 6'($urandom());
    end else begin
      dh = 5'($urandom_range(23)); dm = 6'($urandom_range(59));
      ah = 5'($urandom_range(23)); am = 6'($urandom_range(59));
    end
    send_op(act, key, dh, dm, ah, am, 1'b0, none);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t dir_q [$];
    dir_row_t row;
    outcome_t pres;
    int       phase;
    int       n;
    bit       filling;

    // Directed table: empty and missing-key errors, duplicates, both key
    // extremes, out-of-range time fields, inserts that shift the whole row,
    // deletes at the bottom, middle and top, and a drain back to empty.
    dir_q.push_back(mk(ACT_DELETE, 16'h0000,  0,  0,  0,  0, 1, ST_EMPTY,    0));
    dir_q.push_back(mk(ACT_INSERT, 16'h8000,  0,  0,  0,  0, 1, ST_OK,       1));
    dir_q.push_back(mk(ACT_INSERT, 16'h8000,  1,  2,  3,  4, 1, ST_DUP,      1));
    dir_q.push_back(mk(ACT_DELETE, 16'h1234,  0,  0,  0,  0, 1, ST_NOTFOUND, 1));
    dir_q.push_back(mk(ACT_INSERT, 16'h0000, 23, 59, 23, 59, 1, ST_OK,       2));
    dir_q.push_back(mk(ACT_INSERT, 16'hFFFF, 31, 63, 31, 63, 1, ST_OK,       3));
    dir_q.push_back(mk(ACT_INSERT, 16'hFFFF,  0,  0,  0,  0, 1, ST_DUP,      3));
    dir_q.push_back(mk(ACT_INSERT, 16'h4000,  8, 15, 10, 45, 0, ST_OK,       0));
    dir_q.push_back(mk(ACT_INSERT, 16'h0300, 21, 42, 10, 21, 0, ST_OK,       0));
    dir_q.push_back(mk(ACT_INSERT, 16'h0200, 10, 21, 21, 42, 0, ST_OK,       0));
    dir_q.push_back(mk(ACT_INSERT, 16'hC000, 17, 30,  6,  5, 0, ST_OK,       0));
    dir_q.push_back(mk(ACT_DELETE, 16'h0200, 31, 63, 31, 63, 0, ST_OK,       0));
    dir_q.push_back(mk(ACT_DELETE, 16'h0000,  0,  0,  0,  0, 0, ST_OK,       0));
    dir_q.push_back(mk(ACT_DELETE, 16'hFFFF,  0,  0,  0,  0, 0, ST_OK,       0));
    dir_q.push_back(mk(ACT_DELETE, 16'h7FFF,  0,  0,  0,  0, 1, ST_NOTFOUND, 4));
    dir_q.push_back(mk(ACT_INSERT, 16'h7FFF, 21, 42, 10, 21, 0, ST_OK,       0));
    dir_q.push_back(mk(ACT_DELETE, 16'h4000,  0,  0,  0,  0, 0, ST_OK,       0));
    dir_q.push_back(mk(ACT_DELETE, 16'h0300,  0,  0,  0,  0, 0, ST_OK,       0));
    dir_q.push_back(mk(ACT_DELETE, 16'h8000,  0,  0,  0,  0, 0, ST_OK,       0));
    dir_q.push_back(mk(ACT_DELETE, 16'hC000,  0,  0,  0,  0, 0, ST_OK,       0));
    dir_q.push_back(mk(ACT_DELETE, 16'h7FFF,  0,  0,  0,  0, 1, ST_OK,       0));
    dir_q.push_back(mk(ACT_DELETE, 16'h7FFF,  0,  0,  0,  0, 1, ST_EMPTY,    0));
    dir_q.push_back(mk(ACT_INSERT, 16'h5555, 10, 42, 21, 21, 0, ST_OK,       0));

    for (n = 0; n < 5; n++) status_seen[n] = 0;

    // Single synchronous reset, released on a falling edge.
    repeat (RESET_CYC) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part runs with no idling on either side.
    foreach (dir_q[i]) begin
      row = dir_q[i];
      pres.status = row.st;
      pres.total  = TOT_W'(row.tot);
      send_op(row.act, row.key, row.dh, row.dm, row.ah, row.am, row.pinned, pres);
    end

    // Random part: four idle phases (none, sender only, receiver only, both).
    // Within each, the traffic swings between filling the table until it
    // reports full and draining it until it reports empty, so both boundaries
    // and every shift depth get exercised over and over.
    filling = 1'b1;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (filling && shadow_count == CAPACITY && $urandom_range(7) == 0) filling = 1'b0;
        if (!filling && shadow_count == 0 && $urandom_range(3) == 0) filling = 1'b1;
        random_op(filling ? 80 : 20);
      end
    end
    in_valid <= 1'b0;

    // Wait for every queued result, then let the pipeline settle.
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Covered %0d inserts and %0d deletes, peak occupancy %0d of %0d.",
             n_insert, n_delete, peak_count, CAPACITY);
    $display("Results: ok %0d, full %0d, duplicate %0d, not found %0d, empty %0d.",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_DUP],
             status_seen[ST_NOTFOUND], status_seen[ST_EMPTY]);
    if (errors == 0) begin
      $display("tb_sorted_key_table: done, clean");
    end else begin
      $display("tb_sorted_key_table: done, errors");
    end
    $finish;
  end

endmodule
